// ===== hw/rtl/lkvc_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int RANK_W      = IDX_W;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CFG_W       = 5;
    localparam int CAP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int DATA_W      = 32;

    localparam logic [CFG_W-1:0]         ACTIVE_RESET = CFG_W'(16);
    localparam logic                     ACT_GET      = 1'b0;
    localparam logic                     ACT_SET      = 1'b1;
    localparam logic signed [DATA_W-1:0] MISS_VALUE   = -32'sd1;

    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] lookup_key;
        logic signed [DATA_W-1:0] store_value;
    } cache_req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
    } cache_rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE,
        S_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic match_en;
        logic update_en;
        logic load_rsp;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_get;
        logic rsp_full;
    } dp_sts_t;

endpackage

// ===== hw/rtl/lkvc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lkvc_ram
    import lkvc_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lkvc_ctrl.sv =====
// Control state machine that sequences capture, match, update and response.
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  logic     rsp_stall,
    input  dp_sts_t  sts,
    output ctl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        rsp_free;

    // The output register can take a new result if empty or being drained now.
    assign rsp_free = !sts.rsp_full || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                state_next = sts.is_get ? S_RESP : S_IDLE;
            end
            S_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall     = 1'b1;
        cmd.capture   = 1'b0;
        cmd.match_en  = 1'b0;
        cmd.update_en = 1'b0;
        cmd.load_rsp  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            S_MATCH:
            begin
                cmd.match_en = 1'b1;
            end
            S_UPDATE:
            begin
                cmd.update_en = 1'b1;
            end
            S_RESP:
            begin
                cmd.load_rsp = rsp_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lkvc_dpath.sv =====
// Datapath: key match array, age ranks, occupancy, value RAM and result register.
module lkvc_dpath
    import lkvc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cache_req_t       req,
    input  logic             rsp_stall,
    output cache_rsp_t       rsp,
    output logic             rsp_valid,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    input  ctl_cmd_t         cmd,
    output dp_sts_t          sts
);

    cache_req_t               req_reg;
    logic signed [DATA_W-1:0] key_reg   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]   valid_reg;
    logic [MAX_ENTRIES-1:0]   valid_next;
    logic [RANK_W-1:0]        rank_reg  [MAX_ENTRIES];
    logic [RANK_W-1:0]        rank_next [MAX_ENTRIES];
    logic [CNT_W-1:0]         occ_reg;
    logic [CNT_W-1:0]         occ_next;
    logic [CFG_W-1:0]         active_reg;

    logic                     m_hit_reg;
    logic [IDX_W-1:0]         m_idx_reg;
    logic [IDX_W-1:0]         victim_reg;
    logic [IDX_W-1:0]         free_reg;
    logic                     evict_reg;
    logic                     hit_reg;
    cache_rsp_t               rsp_reg;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;

    logic                     match_any;
    logic [IDX_W-1:0]         match_idx;
    logic [IDX_W-1:0]         victim_idx;
    logic [IDX_W-1:0]         free_idx;
    logic                     free_found;
    logic                     evict;
    logic [CAP_W-1:0]         active_ext;
    logic [CAP_W-1:0]         cap;
    logic [RANK_W-1:0]        last_rank;
    logic [RANK_W-1:0]        promo_rank;
    logic                     is_set;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic                     ram_re;
    logic [DATA_W-1:0]        ram_rdata;

    assign is_set = (req_reg.action == ACT_SET);

    // Effective capacity: zero acts as one, anything above the array size as the size.
    always_comb
    begin
        active_ext = CAP_W'(active_reg);
        if (active_ext == '0)
        begin
            cap = CAP_W'(1);
        end
        else if (active_ext > CAP_W'(MAX_ENTRIES))
        begin
            cap = CAP_W'(MAX_ENTRIES);
        end
        else
        begin
            cap = active_ext;
        end
    end

    // Ranks of valid entries are always a permutation of 0 .. occupancy-1,
    // so the least recent entry is the one holding rank occupancy-1.
    always_comb
    begin
        match_any  = 1'b0;
        match_idx  = '0;
        victim_idx = '0;
        free_idx   = '0;
        free_found = 1'b0;
        evict      = CAP_W'(occ_reg) >= cap;
        last_rank  = RANK_W'(occ_reg - CNT_W'(1));
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (!match_any && valid_reg[i] && key_reg[i] == req_reg.lookup_key)
            begin
                match_any = 1'b1;
                match_idx = IDX_W'(i);
            end
            if (valid_reg[i] && rank_reg[i] == last_rank)
            begin
                victim_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (!free_found && (!valid_reg[i] || (evict && victim_idx == IDX_W'(i))))
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.match_en)
        begin
            m_hit_reg  <= match_any;
            m_idx_reg  <= match_idx;
            victim_reg <= victim_idx;
            free_reg   <= free_idx;
            evict_reg  <= evict;
        end
        if (cmd.update_en)
        begin
            hit_reg <= m_hit_reg;
            if (is_set && !m_hit_reg)
            begin
                key_reg[free_reg] <= req_reg.lookup_key;
            end
        end
        if (cmd.load_rsp)
        begin
            rsp_reg.hit        <= hit_reg;
            rsp_reg.read_value <= hit_reg ? $signed(ram_rdata) : MISS_VALUE;
        end
    end

    assign promo_rank = rank_reg[m_idx_reg];

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (cmd.update_en)
        begin
            if (is_set && !m_hit_reg)
            begin
                // Insert: drop the least recent if full, age the rest, new entry is rank 0.
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    if (free_reg == IDX_W'(i))
                    begin
                        valid_next[i] = 1'b1;
                        rank_next[i]  = '0;
                    end
                    else if (evict_reg && victim_reg == IDX_W'(i))
                    begin
                        valid_next[i] = 1'b0;
                        rank_next[i]  = '0;
                    end
                    else if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
                occ_next = evict_reg ? occ_reg : occ_reg + CNT_W'(1);
            end
            else if (m_hit_reg)
            begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    if (m_idx_reg == IDX_W'(i))
                    begin
                        rank_next[i] = '0;
                    end
                    else if (valid_reg[i] && rank_reg[i] < promo_rank)
                    begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            occ_reg       <= '0;
            active_reg    <= ACTIVE_RESET;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg     <= valid_next;
            occ_reg       <= occ_next;
            rsp_valid_reg <= rsp_valid_next;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= cfg_data;
            end
        end
    end

    assign ram_we    = cmd.update_en && is_set;
    assign ram_waddr = m_hit_reg ? m_idx_reg : free_reg;
    assign ram_re    = cmd.update_en && !is_set && m_hit_reg;

    lkvc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ENTRIES)
    ) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req_reg.store_value),
        .re    (ram_re),
        .raddr (m_idx_reg),
        .rdata (ram_rdata)
    );

    assign sts.is_get   = (req_reg.action == ACT_GET);
    assign sts.rsp_full = rsp_valid_reg;
    assign rsp          = rsp_reg;
    assign rsp_valid    = rsp_valid_reg;

endmodule

// ===== hw/rtl/lru_key_value_cache_core.sv =====
// Top level of the fully associative LRU key/value cache.
//
// Requests arrive on req/req_valid and transfer when req_valid is high and
// req_stall is low. A get (action 0) produces one response on rsp/rsp_valid,
// which transfers when rsp_valid is high and rsp_stall is low. A set
// (action 1) inserts or updates an entry and produces no response.
// One request is processed at a time: capture, key match against all
// entries, state update with a value RAM access, then, for a get,
// response load. A set returns from its update state to idle, where the
// next request can transfer. A get response is valid once the response
// load has filled the output register; the load waits while that
// register is full and stalled, and the next request transfers after it.
// A stalled response stays in the output register and the next request is
// still taken; only a second get result waiting on a full register holds.
// The capacity register is written through cfg_data/cfg_valid; cfg_ready is
// always high. Write it only while no request is in flight.
// Reset clears all valid bits, age ranks and the occupancy, and sets the
// capacity to the full array; keys and values are undefined until written.
module lru_key_value_cache_core
    import lkvc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  cache_req_t       req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output cache_rsp_t       rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    assign cfg_ready = 1'b1;

    lkvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    lkvc_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== hw/rtl/lkvc_checker.sv =====
// Port-level checks for the LRU key/value cache, bound to the top level.
module lkvc_checker
    import lkvc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_stall,
    input cache_req_t       req,
    input logic             rsp_valid,
    input logic             rsp_stall,
    input cache_rsp_t       rsp,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic [CFG_W-1:0] cfg_data
);

    // A stalled response must hold.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // A miss always reports the miss value.
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.hit |-> rsp.read_value == MISS_VALUE)
        else $error("miss response without miss value");

    // After a request transfer the block is busy for the next cycle.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    // A fresh response must trace back to an earlier get transfer.
    a_rsp_from_get: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && !req_stall && req.action == ACT_GET, 4))
        else $error("response without matching get");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (.*);

// ===== tb/sv/lru_key_value_cache_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the LRU key/value cache core with a shadow cache predictor.
module lru_key_value_cache_core_tb;
    import lkvc_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RSP_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 12;
    localparam int MAX_REPORTS     = 10;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    cache_req_t       req;
    logic             rsp_valid;
    logic             rsp_stall;
    cache_rsp_t       rsp;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    // Shadow copy of the cache contents, recency order and capacity register.
    logic [DATA_W-1:0] shadow_key   [MAX_ENTRIES];
    logic [DATA_W-1:0] shadow_value [MAX_ENTRIES];
    bit                shadow_valid [MAX_ENTRIES];
    int unsigned       shadow_rank  [MAX_ENTRIES];
    int unsigned       shadow_count = 0;
    logic [CFG_W-1:0]  shadow_capacity;

    cache_rsp_t        expected_reads[$];
    logic [DATA_W-1:0] key_pool[$];
    int                mismatch_count = 0;
    int                idle_cycles    = 0;
    int                req_idle_pct   = 8;
    int                rsp_stall_pct  = 8;
    bit                hold_rsp_req   = 1'b0;

    lru_key_value_cache_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int unsigned effective_capacity();
        int unsigned c;
        c = 32'(shadow_capacity);
        if (c == 0)
            return 1;
        if (c > MAX_ENTRIES)
            return MAX_ENTRIES;
        return c;
    endfunction

    // Entries that were more recent than the touched one age by one step.
    function automatic void make_recent(int slot);
        int unsigned r;
        r = shadow_rank[slot];
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (shadow_valid[i] && shadow_rank[i] < r)
                shadow_rank[i]++;
        shadow_rank[slot] = 0;
    endfunction

    function automatic void apply_request(cache_req_t item);
        int          slot;
        int          victim;
        int          free_slot;
        int unsigned worst;
        cache_rsp_t  want;
        slot = -1;
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (slot < 0 && shadow_valid[i] && shadow_key[i] == item.lookup_key)
                slot = i;
        if (item.action == ACT_GET)
        begin
            if (slot >= 0)
            begin
                make_recent(slot);
                want.hit        = 1'b1;
                want.read_value = shadow_value[slot];
            end
            else
            begin
                want.hit        = 1'b0;
                want.read_value = MISS_VALUE;
            end
            expected_reads.push_back(want);
        end
        else if (slot >= 0)
        begin
            shadow_value[slot] = item.store_value;
            make_recent(slot);
        end
        else
        begin
            if (shadow_count >= effective_capacity())
            begin
                victim = -1;
                worst  = 0;
                for (int i = 0; i < MAX_ENTRIES; i++)
                    if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > worst))
                    begin
                        victim = i;
                        worst  = shadow_rank[i];
                    end
                if (victim >= 0)
                begin
                    shadow_valid[victim] = 1'b0;
                    shadow_rank[victim]  = 0;
                    if (shadow_count > 0)
                        shadow_count--;
                end
            end
            free_slot = -1;
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (free_slot < 0 && !shadow_valid[i])
                    free_slot = i;
            if (free_slot >= 0)
            begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                    if (shadow_valid[i])
                        shadow_rank[i]++;
                shadow_key[free_slot]   = item.lookup_key;
                shadow_value[free_slot] = item.store_value;
                shadow_valid[free_slot] = 1'b1;
                shadow_rank[free_slot]  = 0;
                shadow_count++;
            end
        end
    endfunction

    function automatic logic [DATA_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 85 && key_pool.size() != 0)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        if (roll < 95)
            return $urandom();
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // Holds the request until it transfers, then may leave a short gap.
    task automatic send_req(input logic act, input logic [DATA_W-1:0] key,
                            input logic [DATA_W-1:0] value);
        cache_req_t item;
        item.action      = act;
        item.lookup_key  = key;
        item.store_value = value;
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        apply_request(item);
        if ($urandom_range(99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic req_quiet();
        req_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Sets produce no response, so a fixed drain follows the last expected read.
    task automatic write_capacity(input logic [CFG_W-1:0] value);
        req_quiet();
        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_capacity = value;
    endtask

    task automatic run_random_phase(input logic [CFG_W-1:0] cap, input int items,
                                    input int set_pct);
        write_capacity(cap);
        key_pool.delete();
        repeat (effective_capacity() + $urandom_range(1, 6))
            key_pool.push_back($urandom());
        repeat (items)
            send_req(($urandom_range(99) < set_pct) ? ACT_SET : ACT_GET, pick_key(),
                     $urandom());
    endtask

    task automatic test_basic_ops();
        send_req(ACT_GET, 32'h0000_0000, 32'h0000_0000);
        send_req(ACT_SET, 32'h8000_0000, 32'h7fff_ffff);
        send_req(ACT_SET, 32'h7fff_ffff, 32'h8000_0000);
        send_req(ACT_SET, 32'h0000_0000, 32'h0000_0000);
        send_req(ACT_SET, 32'hffff_ffff, 32'hffff_ffff);
        send_req(ACT_GET, 32'h8000_0000, 32'h0000_0000);
        send_req(ACT_GET, 32'h7fff_ffff, 32'hffff_ffff);
        send_req(ACT_GET, 32'h0000_0000, 32'h0000_0000);
        send_req(ACT_GET, 32'hffff_ffff, 32'h0000_0000);
        send_req(ACT_GET, 32'h1234_5678, 32'h0000_0000);
        send_req(ACT_SET, 32'h0000_0000, 32'h5a5a_a5a5);
        send_req(ACT_GET, 32'h0000_0000, 32'h0000_0000);
    endtask

    // Capacity below occupancy, zero capacity and capacity above the array size.
    task automatic test_capacity_limits();
        write_capacity(CFG_W'(2));
        send_req(ACT_SET, 32'h0000_0001, 32'h0000_1111);
        send_req(ACT_GET, 32'h8000_0000, 32'h0000_0000);
        send_req(ACT_GET, 32'h0000_0001, 32'h0000_0000);
        write_capacity(CFG_W'(0));
        send_req(ACT_SET, 32'h0000_0002, 32'h0000_2222);
        send_req(ACT_SET, 32'h0000_0003, 32'h0000_3333);
        send_req(ACT_GET, 32'h0000_0002, 32'h0000_0000);
        send_req(ACT_GET, 32'h0000_0003, 32'h0000_0000);
        write_capacity(CFG_W'(31));
        send_req(ACT_SET, 32'h0000_0004, 32'h0000_4444);
        send_req(ACT_GET, 32'h0000_0004, 32'h0000_0000);
        send_req(ACT_GET, 32'h0000_0001, 32'h0000_0000);
    endtask

    task automatic test_random_mix();
        run_random_phase(CFG_W'(16), 70, 50);
        run_random_phase(CFG_W'(1), 60, 50);
        run_random_phase(CFG_W'(17), 70, 55);
        run_random_phase(CFG_W'(5), 60, 45);
        run_random_phase(CFG_W'(0), 50, 50);
        run_random_phase(CFG_W'(31), 70, 60);
        run_random_phase(CFG_W'(2), 60, 50);
        run_random_phase(CFG_W'(12), 70, 50);
        run_random_phase(CFG_W'(8), 60, 50);
    endtask

    task automatic test_back_to_back();
        req_idle_pct  = 0;
        rsp_stall_pct = 0;
        run_random_phase(CFG_W'(16), 80, 40);
        req_idle_pct  = 8;
        rsp_stall_pct = 8;
    endtask

    // The response side holds off while gets keep coming, so the output register fills and requests stall.
    task automatic test_receiver_hold();
        hold_rsp_req = 1'b1;
        repeat (40)
            send_req(($urandom_range(99) < 25) ? ACT_SET : ACT_GET, pick_key(), $urandom());
    endtask

    initial
    begin
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rsp_req)
            begin
                hold_rsp_req = 1'b0;
                rsp_stall <= 1'b1;
                repeat (RSP_HOLD_CYCLES) @(posedge clk);
            end
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cache_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_reads.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: response with none pending: hit %0b value %h",
                             $realtime, rsp.hit, rsp.read_value);
            end
            else
            begin
                want = expected_reads.pop_front();
                if (rsp.hit !== want.hit || rsp.read_value !== want.read_value)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mismatch: expected hit %0b value %h, got %0b %h",
                                 $realtime, want.hit, want.read_value, rsp.hit,
                                 rsp.read_value);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        shadow_capacity = ACTIVE_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_ops();
        test_capacity_limits();
        test_random_mix();
        test_back_to_back();
        test_receiver_hold();
        req_quiet();
        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
